>>> hw/rtl/moq_pkg.sv
// Shared types and constants for the median-of-three quicksort block.
// No dependencies.
`default_nettype none
package moq_pkg;
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 32;
  localparam int SHORT_RANGE = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [14:0] {
    S_LOAD   = 15'h0001,
    S_POP    = 15'h0002,
    S_POPRD  = 15'h0004,
    S_CSRD   = 15'h0008,
    S_CSWAIT = 15'h0010,
    S_CSCMP  = 15'h0020,
    S_CSWR   = 15'h0040,
    S_PIVRD  = 15'h0080,
    S_PIVWT  = 15'h0100,
    S_SCANI  = 15'h0200,
    S_SCANJ  = 15'h0400,
    S_SWAP   = 15'h0800,
    S_PUSH   = 15'h1000,
    S_OUTRD  = 15'h2000,
    S_OUT    = 15'h4000
  } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/median_of_three_quicksort.sv
// Top level of the median-of-three quicksort block: load, sort and emit.
// Depends on moq_pkg.
//
// Usage. Segments arrive on the input channel (valid/ready), one item per
// cycle while loading: each item writes min(x_first, x_second) and its load
// position into the store. A load that finds the store full is discarded and
// raises the dropped flag for the set. The item marked last_item starts the
// sort; the block then drops ready until every result has been delivered.
// The sort is a quicksort with an explicit range stack, run by one sequencer
// around one store read port per cycle; keys are compared at load, in the
// compare-swaps and in both scans. Each store read is registered (address,
// then data). A compare-swap reads both entries and writes them back, one
// after the other, only when they are out of order; a swap in the partition
// loop always writes both. Results then leave in ascending key order, each
// one read from the store after the previous one has been taken, with
// final_result on the last one. A stalled receiver simply holds the result
// register; nothing is lost. Reset empties the store and clears the overflow
// record behind the dropped flag; the store contents themselves are not
// cleared, as only written entries are ever read.
`default_nettype none
module median_of_three_quicksort import moq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid_in,
  output logic                   ready_in,
  input  wire logic signed [31:0] x_first,
  input  wire logic signed [31:0] x_second,
  input  wire logic              last_item,
  output logic                   valid_out,
  input  wire logic              ready_out,
  output logic [5:0]             load_index,
  output logic signed [31:0]     sort_key,
  output logic                   final_result,
  output logic                   dropped
);
  // Key and index live in one memory word; the range stack is a second memory.
  logic [KEY_W+IDX_W-1:0] store [MAX_ITEMS];
  logic [2*IDX_W-1:0]     stack [MAX_ITEMS];

  state_t state;
  cnt_t   count;
  logic   overflow;
  cnt_t   sp;
  idx_t   l, r, m, i, j, pa, pb;
  logic [1:0] cs_step;
  key_t   pivot;
  logic [KEY_W+IDX_W-1:0] ea, eb, rd;
  logic   rd_b;
  cnt_t   ocnt;
  logic [2*IDX_W-1:0] stk_rd;

  // Store port: one write and one read per cycle.
  logic   we;
  idx_t   waddr, raddr;
  logic [KEY_W+IDX_W-1:0] wdata;
  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    rd <= store[raddr];
    stk_rd <= stack[sp[IDX_W-1:0] - idx_t'(1)];
  end

  logic stk_we;
  logic [2*IDX_W-1:0] stk_wd;
  always_ff @(posedge clk) begin
    if (stk_we) stack[sp[IDX_W-1:0]] <= stk_wd;
  end

  key_t ka, kb, kin;
  assign ka = key_t'(ea[KEY_W+IDX_W-1:IDX_W]);
  assign kb = key_t'(eb[KEY_W+IDX_W-1:IDX_W]);
  assign kin = (x_first < x_second) ? x_first : x_second;
  logic gt;
  assign gt = ka > kb;

  logic swp_phase;  // second write of a swap
  logic do_push_r;  // which push is pending

  always_comb begin
    we = 1'b0; waddr = pa; wdata = ea; raddr = pa;
    case (state)
      S_LOAD: begin
        we = valid_in && count != cnt_t'(MAX_ITEMS);
        waddr = count[IDX_W-1:0];
        wdata = {kin, count[IDX_W-1:0]};
      end
      S_CSRD, S_PIVRD: raddr = rd_b ? pb : pa;
      S_CSWAIT: raddr = pb;
      S_CSWR, S_SWAP: begin
        // A compare-swap writes back only when the pair is out of order.
        we = (state == S_SWAP) || gt;
        waddr = swp_phase ? pb : pa;
        wdata = swp_phase ? ea : eb;
      end
      S_SCANI: raddr = i;
      S_SCANJ: raddr = j;
      S_OUTRD: raddr = ocnt[IDX_W-1:0];
      default: ;
    endcase
  end

  assign ready_in = state == S_LOAD;
  assign stk_we = state == S_PUSH || (state == S_LOAD && valid_in && last_item);

  cnt_t n_eff;
  assign n_eff = (valid_in && count != cnt_t'(MAX_ITEMS)) ? count + cnt_t'(1) : count;

  always_comb begin
    stk_wd = {i, r};
    if (state == S_LOAD) stk_wd = {idx_t'(0), idx_t'(n_eff - cnt_t'(1))};
    else if (!do_push_r) stk_wd = {l, j};
  end

  // Pair selection for the three compare-swaps of median-of-three.
  function automatic logic [2*IDX_W-1:0] cs_pair(input logic [1:0] s, input idx_t ll,
                                                  input idx_t mm, input idx_t rr);
    case (s)
      2'd1: cs_pair = {mm, rr};
      default: cs_pair = {ll, mm};
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; count <= '0; overflow <= 1'b0; sp <= '0;
      valid_out <= 1'b0; swp_phase <= 1'b0; rd_b <= 1'b0;
    end else begin
      case (state)
        S_LOAD: if (valid_in) begin
          if (count != cnt_t'(MAX_ITEMS)) count <= n_eff;
          else overflow <= 1'b1;
          if (last_item) begin
            count <= n_eff;
            if (count == cnt_t'(MAX_ITEMS)) overflow <= 1'b1;
            ocnt <= '0;
            if (n_eff > cnt_t'(1)) begin
              sp <= cnt_t'(1);
              state <= S_POP;
            end else begin
              state <= S_OUTRD;
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            state <= S_OUTRD;
          end else begin
            sp <= sp - cnt_t'(1);
            state <= S_POPRD;
          end
        end
        S_POPRD: begin
          l <= stk_rd[2*IDX_W-1:IDX_W];
          r <= stk_rd[IDX_W-1:0];
          m <= idx_t'(({1'b0, stk_rd[2*IDX_W-1:IDX_W]} + {1'b0, stk_rd[IDX_W-1:0]}) >> 1);
          if (idx_t'(({1'b0, stk_rd[2*IDX_W-1:IDX_W]} + {1'b0, stk_rd[IDX_W-1:0]}) >> 1)
              == stk_rd[2*IDX_W-1:IDX_W]) begin
            cs_step <= 2'd3;
            pa <= stk_rd[2*IDX_W-1:IDX_W];
            pb <= stk_rd[IDX_W-1:0];
          end else begin
            cs_step <= 2'd0;
            pa <= stk_rd[2*IDX_W-1:IDX_W];
            pb <= idx_t'(({1'b0, stk_rd[2*IDX_W-1:IDX_W]} + {1'b0, stk_rd[IDX_W-1:0]}) >> 1);
          end
          rd_b <= 1'b0;
          state <= S_CSRD;
        end
        // Read pa, then pb.
        S_CSRD: state <= S_CSWAIT;
        S_CSWAIT: begin ea <= rd; state <= S_CSCMP; end
        S_CSCMP: begin
          eb <= rd;
          state <= S_CSWR;
          swp_phase <= 1'b0;
        end
        S_CSWR: begin
          if (!gt) begin
            state <= S_PIVRD; swp_phase <= 1'b0;
          end else if (!swp_phase) begin
            swp_phase <= 1'b1;
          end else begin
            swp_phase <= 1'b0; state <= S_PIVRD;
          end
          if (!gt || swp_phase) begin
            // Next compare-swap, on to partitioning, or back to pop for a short range.
            if (cs_step == 2'd3 || (cs_step == 2'd2 && r - l < idx_t'(SHORT_RANGE))) begin
              state <= S_POP;
            end else if (cs_step == 2'd2) begin
              pa <= m; rd_b <= 1'b0; state <= S_PIVRD;
            end else begin
              {pa, pb} <= cs_pair(cs_step + 2'd1, l, m, r);
              cs_step <= cs_step + 2'd1;
              state <= S_CSRD;
            end
          end
        end
        S_PIVRD: state <= S_PIVWT;
        S_PIVWT: begin
          pivot <= key_t'(rd[KEY_W+IDX_W-1:IDX_W]);
          i <= l + idx_t'(1); j <= r - idx_t'(1);
          state <= S_SCANI;
          rd_b <= 1'b0;
        end
        // rd_b marks that the read for the current index has landed.
        S_SCANI: begin
          if (!rd_b) begin
            rd_b <= 1'b1;
          end else if (i < r && pivot > key_t'(rd[KEY_W+IDX_W-1:IDX_W])) begin
            i <= i + idx_t'(1); rd_b <= 1'b0;
          end else begin
            ea <= rd; rd_b <= 1'b0; state <= S_SCANJ;
          end
        end
        S_SCANJ: begin
          if (!rd_b) begin
            rd_b <= 1'b1;
          end else if (j > l && key_t'(rd[KEY_W+IDX_W-1:IDX_W]) > pivot) begin
            j <= j - idx_t'(1); rd_b <= 1'b0;
          end else begin
            eb <= rd; rd_b <= 1'b0;
            if (i < j) begin
              pa <= i; pb <= j; swp_phase <= 1'b0; state <= S_SWAP;
            end else begin
              state <= S_PUSH; do_push_r <= 1'b1;
            end
          end
        end
        S_SWAP: begin
          if (!swp_phase) swp_phase <= 1'b1;
          else begin
            swp_phase <= 1'b0;
            i <= i + idx_t'(1); j <= j - idx_t'(1);
            // The partition loop goes on only while the indices have not met.
            if (i + idx_t'(1) < j - idx_t'(1)) begin
              state <= S_SCANI;
            end else begin
              state <= S_PUSH; do_push_r <= 1'b1;
            end
          end
        end
        S_PUSH: begin
          if (do_push_r) begin
            do_push_r <= 1'b0;
            if (i < r) sp <= sp + cnt_t'(1);
          end else begin
            if (l < j) sp <= sp + cnt_t'(1);
            state <= S_POP;
          end
        end
        S_OUTRD: begin
          if (!valid_out || ready_out) begin
            valid_out <= 1'b0;
            if (ocnt == count) begin
              count <= '0; overflow <= 1'b0; state <= S_LOAD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          valid_out <= 1'b1;
          load_index <= rd[IDX_W-1:0];
          sort_key <= key_t'(rd[KEY_W+IDX_W-1:IDX_W]);
          final_result <= ocnt == count - cnt_t'(1);
          dropped <= overflow;
          ocnt <= ocnt + cnt_t'(1);
          state <= S_OUTRD;
        end
        default: state <= S_LOAD;
      endcase
      if (state == S_LOAD && valid_out && ready_out) valid_out <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/moq_checker.sv
// Port-level checks for median_of_three_quicksort, bound to the top level.
// Depends on moq_pkg.
`default_nettype none
module moq_checker import moq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic ready_in,
  input wire logic valid_out,
  input wire logic ready_out,
  input wire logic final_result
);
  // While results are pending, no new item is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> !ready_in) else $error("ready while results pending");
  // A result stalled by the receiver holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out) else $error("result dropped");
  // After a last result is taken, no further result in the next cycle.
  a_end: assert property (@(posedge clk) disable iff (rst)
    valid_out && ready_out && final_result |=> !valid_out) else $error("extra result");
  // Reset clears any pending result.
  a_rst: assert property (@(posedge clk) rst |=> !valid_out)
    else $error("result after reset");
endmodule

bind median_of_three_quicksort moq_checker u_moq_checker (
  .clk(clk), .rst(rst), .ready_in(ready_in),
  .valid_out(valid_out), .ready_out(ready_out), .final_result(final_result)
);
`default_nettype wire
